/* design/sobel_gradient_magnitude_direction_macros.svh */
// ---------------------------------------------------------------------------
// Sobel gradient assertion macros
// Shared concurrent assertion forms for the Sobel gradient block.
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_DIRECTION_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DIRECTION_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SGM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgm assertion failed");

// next-cycle implication
`define SGM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgm assertion failed");

`else

`define SGM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SGM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/sgm_pkg.sv */
// ---------------------------------------------------------------------------
// Sobel gradient package
// Shared widths, types and constants.
// ---------------------------------------------------------------------------
package sgm_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int WIDTH_BITS    = 11;
   localparam int HEIGHT_BITS   = 13;
   localparam int ROW_BITS      = 14;
   localparam int QUEUE_DEPTH   = 4;
   localparam int COUNT_BITS    = 3;
   localparam int PADDR_BITS    = 3;

   // register indexes (paddr[2])
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // direction codes
   localparam logic [2:0] DIR_0   = 3'd0;
   localparam logic [2:0] DIR_45  = 3'd1;
   localparam logic [2:0] DIR_90  = 3'd2;
   localparam logic [2:0] DIR_135 = 3'd3;
   localparam logic [2:0] DIR_180 = 3'd4;

   // unit vectors at 1, 23, 68, 113, 158 degrees, scaled by 1e12
   localparam logic signed [40:0] DIR_COS [5] = '{
      41'sd999847695156, 41'sd920504853452, 41'sd374606593416,
      -41'sd390731128489, -41'sd927183854567};
   localparam logic signed [40:0] DIR_SIN [5] = '{
      41'sd17452406437, 41'sd390731128489, 41'sd927183854567,
      41'sd920504853452, 41'sd374606593416};

   typedef logic [8:0][7:0] win_type;

   typedef struct packed {
      win_type win;
      logic    last;
   } q_word_type;

   typedef struct packed {
      logic                   restart;
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
   } cfg_type;

endpackage

/* design/sgm_ifs.sv */
// ---------------------------------------------------------------------------
// Sobel gradient channels
// Pixel request channel and gradient result channel.
// ---------------------------------------------------------------------------
interface sgm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       flush;
   modport source (output valid, output pixel, output flush, input ready);
   modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface sgm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] magnitude;
   logic [2:0] direction_bin;
   logic       frame_last;
   modport source (output valid, output magnitude, output direction_bin,
                   output frame_last, input ready);
   modport sink (input valid, input magnitude, input direction_bin,
                 input frame_last, output ready);
endinterface

/* design/sobel_gradient_magnitude_direction.sv */
// ---------------------------------------------------------------------------
// Sobel gradient magnitude and direction
// Streaming 3x3 Sobel filter giving rounded magnitude and a 45 degree bin.
// ---------------------------------------------------------------------------
// Grey pixels go in on req_port in raster order, one word per clock while
// ready is high; each output word comes image_width+1 input words behind
// its pixel, so after a frame's last pixel send image_width+1 words with
// flush set to drain it (the final result carries frame_last). Flush words
// sent mid-frame are dropped. Neighbours outside the image count as zero.
// Sustained rate is one pixel per clock while the window queue has room,
// set by the line memory taking one read and one write each cycle; the
// back end is a 12-stage pipeline (kernel sum, 0.7 scaling, squares, eight
// root/direction steps, output register) that stalls as a whole while a
// result waits on rsp_port. No clearing pass after reset is needed: every
// line entry is rewritten before it is used within a frame. Writing
// image_width (0x0) or image_height (0x4) restarts the frame; write them only
// while the block is idle.
// ---------------------------------------------------------------------------
module sobel_gradient_magnitude_direction #(
   parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   sgm_req_if.sink                        req_port,
   sgm_rsp_if.source                      rsp_port,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sgm_pkg::PADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import sgm_pkg::*;

   `include "sobel_gradient_magnitude_direction_macros.svh"

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic                   cfg_we;
   cfg_type                cfg;

   logic                   q_push, q_pop, q_valid;
   q_word_type             q_in, q_out;
   logic [COUNT_BITS-1:0]  q_count;

   // register port: zero-wait writes and reads
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(640);
         height_ff <= HEIGHT_BITS'(480);
      end else if (cfg_we) begin
         if (paddr[2] == REG_WIDTH) begin
            width_ff <= pwdata[WIDTH_BITS-1:0];
         end else begin
            height_ff <= pwdata[HEIGHT_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_HEIGHT) begin
         prdata = 32'(height_ff);
      end else begin
         prdata = 32'(width_ff);
      end
   end

   assign cfg.restart = cfg_we;
   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;

   // front: counters, line memory, window
   sgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .cfg      (cfg),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   // windows waiting for the arithmetic pipe
   sgm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_out),
      .count     (q_count)
   );

   // back: gradient arithmetic and output register
   sgm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_out),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

   // queue never overruns and is never popped empty
   `SGM_ASSERT_IMPLY(a_q_bound, clock, reset, 1'b1, q_count <= COUNT_BITS'(QUEUE_DEPTH))
   `SGM_ASSERT_IMPLY(a_push_room, clock, reset, q_push && !q_pop,
                     q_count < COUNT_BITS'(QUEUE_DEPTH))
   `SGM_ASSERT_IMPLY(a_pop_nonempty, clock, reset, q_pop, q_count != '0)
   // a push is always followed by a non-empty queue
   `SGM_ASSERT_NEXT(a_push_fill, clock, reset, q_push, q_count != '0)

endmodule

/* design/sgm_queue.sv */
// ---------------------------------------------------------------------------
// Sobel window queue
// Small FIFO of 3x3 windows between front and back.
// ---------------------------------------------------------------------------
module sgm_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  sgm_pkg::q_word_type           push_data,
   input  logic                          pop,
   output logic                          valid,
   output sgm_pkg::q_word_type           data,
   output logic [sgm_pkg::COUNT_BITS-1:0] count
);
   import sgm_pkg::*;

   q_word_type      entry_ff [QUEUE_DEPTH];
   logic [1:0]      wr_ptr_ff;
   logic [1:0]      rd_ptr_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign valid = (count_ff != '0);
   assign data  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

/* design/sgm_front.sv */
// ---------------------------------------------------------------------------
// Sobel front end
// Raster counters, line memory and 3x3 window; queues each window to emit.
// ---------------------------------------------------------------------------
module sgm_front #(
   parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   sgm_req_if.sink                        req_port,
   input  sgm_pkg::cfg_type               cfg,
   input  logic [sgm_pkg::COUNT_BITS-1:0] q_count,
   output logic                           q_push,
   output sgm_pkg::q_word_type            q_data
);
   import sgm_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   typedef struct packed {
      logic [AW-1:0] addr;
      logic          first_col;
      logic          has_top;
      logic          has_mid;
      logic          emit;
      logic          last;
      logic [7:0]    bot;
   } s1_type;

   // line memory: high byte = row before last, low byte = last row
   logic [15:0]           line_mem [MAX_WIDTH];
   logic [15:0]           rd_ff;
   logic [15:0]           wr_data_ff;
   logic [AW-1:0]         wr_addr_ff;
   logic                  wr_valid_ff;

   logic [AW-1:0]         col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  s1_valid_ff;
   s1_type                s1_ff, s1_in;
   win_type               win_ff, win_in, win_emit;

   logic [ROW_BITS-1:0]   w_eff, h_eff, cc, rr, col_ext;
   logic                  accept, guard, ignore, last_row;
   logic [15:0]           word;
   logic [7:0]            top, mid;
   logic [2:0][7:0]       new_col;

   // clamped geometry
   always_comb begin
      if (cfg.width == '0) begin
         w_eff = ROW_BITS'(1);
      end else if (32'(cfg.width) > MAX_WIDTH) begin
         w_eff = ROW_BITS'(MAX_WIDTH);
      end else begin
         w_eff = ROW_BITS'(cfg.width);
      end
      if (cfg.height == '0) begin
         h_eff = ROW_BITS'(1);
      end else if (32'(cfg.height) > HEIGHT_LIMIT) begin
         h_eff = ROW_BITS'(HEIGHT_LIMIT);
      end else begin
         h_eff = ROW_BITS'(cfg.height);
      end
   end

   assign req_port.ready = (q_count <= COUNT_BITS'(QUEUE_DEPTH - 2));
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      col_ext  = ROW_BITS'(col_ff);
      guard    = (col_ext >= w_eff) || (row_ff > h_eff + 1'b1);
      cc       = guard ? '0 : col_ext;
      rr       = guard ? '0 : row_ff;
      ignore   = req_port.flush && (rr < h_eff);
      last_row = (rr == h_eff + 1'b1);

      col_in = AW'(cc);
      row_in = rr;
      if (!ignore) begin
         if (last_row) begin
            col_in = '0;
            row_in = '0;
         end else if (cc + 1'b1 >= w_eff) begin
            col_in = '0;
            row_in = rr + 1'b1;
         end else begin
            col_in = AW'(cc + 1'b1);
         end
      end

      s1_in.addr      = AW'(cc);
      s1_in.first_col = (cc == '0);
      s1_in.has_top   = (rr >= ROW_BITS'(2));
      s1_in.has_mid   = (rr >= ROW_BITS'(1));
      s1_in.emit      = (cc == '0) ? (rr >= ROW_BITS'(2)) : (rr >= ROW_BITS'(1));
      s1_in.last      = (cc == '0) && last_row;
      s1_in.bot       = (rr < h_eff) ? req_port.pixel : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= accept && !ignore;
         if (s1_valid_ff) begin
            wr_valid_ff <= 1'b1;
            win_ff      <= win_in;
         end
         if (cfg.restart) begin
            col_ff <= '0;
            row_ff <= '0;
            win_ff <= '0;
         end else if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // payload and line memory
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
         rd_ff <= line_mem[AW'(cc)];
      end
      if (s1_valid_ff) begin
         line_mem[s1_ff.addr] <= {word[7:0], s1_ff.bot};
         wr_data_ff           <= {word[7:0], s1_ff.bot};
         wr_addr_ff           <= s1_ff.addr;
      end
   end

   // window update; last write forwarded when the same column is read back
   always_comb begin
      word = (wr_valid_ff && wr_addr_ff == s1_ff.addr) ? wr_data_ff : rd_ff;
      top  = s1_ff.has_top ? word[15:8] : 8'd0;
      mid  = s1_ff.has_mid ? word[7:0] : 8'd0;
      new_col[0] = s1_ff.first_col ? 8'd0 : top;
      new_col[1] = s1_ff.first_col ? 8'd0 : mid;
      new_col[2] = s1_ff.first_col ? 8'd0 : s1_ff.bot;
      for (int j = 0; j < 3; j++) begin
         win_emit[j*3]     = win_ff[j*3+1];
         win_emit[j*3 + 1] = win_ff[j*3+2];
         win_emit[j*3 + 2] = new_col[j];
      end
      if (s1_ff.first_col) begin
         win_in    = '0;
         win_in[2] = top;
         win_in[5] = mid;
         win_in[8] = s1_ff.bot;
      end else begin
         win_in = win_emit;
      end
   end

   assign q_push      = s1_valid_ff && s1_ff.emit;
   assign q_data.win  = win_emit;
   assign q_data.last = s1_ff.last;

endmodule

/* design/sgm_back.sv */
// ---------------------------------------------------------------------------
// Sobel back end
// Kernel sums, 0.7 scaling, rounded root and direction bin, pipelined.
// ---------------------------------------------------------------------------
module sgm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  sgm_pkg::q_word_type q_data,
   output logic                q_pop,
   sgm_rsp_if.source           rsp_port
);
   import sgm_pkg::*;

   localparam int NSQ = 8;

   typedef struct packed {
      logic               valid;
      logic [19:0]        sq;
      logic [7:0]         root;
      logic signed [10:0] sx;
      logic [9:0]         ay;
      logic               sy_zero;
      logic               sy_neg;
      logic [4:0]         below;
      logic               last;
   } st_type;

   logic               en;
   logic               a_valid_ff, b_valid_ff;
   logic signed [10:0] gx_ff, gy_ff, sx_ff, sy_ff;
   logic               a_last_ff, b_last_ff;
   st_type             st_ff [NSQ+1];
   st_type             st_in [NSQ+1];

   logic signed [11:0] p [9];
   logic signed [10:0] gx_in, gy_in, sx_in, sy_in;
   logic [9:0]         ax, ay;

   logic               out_valid_ff;
   logic [7:0]         mag_ff;
   logic [2:0]         dir_ff, dir_in;
   logic               last_ff;

   function automatic logic signed [10:0] scale7(input logic signed [10:0] g);
      logic [9:0]  a;
      logic [12:0] a7;
      logic [25:0] prod;
      logic [9:0]  q;
      a    = g[10] ? 10'(-g) : 10'(g);
      a7   = {a, 3'b000} - 13'(a);
      prod = 26'(a7) * 26'd6554;   // divide by ten, exact below 7141
      q    = prod[25:16];
      return g[10] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   assign en    = !out_valid_ff || rsp_port.ready;
   assign q_pop = en && q_valid;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         p[k] = $signed({4'b0000, q_data.win[k]});
      end
      gx_in = 11'((p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]));
      gy_in = 11'((p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]));
      sx_in = scale7(gx_ff);
      sy_in = scale7(gy_ff);
      ax    = sx_ff[10] ? 10'(-sx_ff) : 10'(sx_ff);
      ay    = sy_ff[10] ? 10'(-sy_ff) : 10'(sy_ff);

      st_in[0].valid   = b_valid_ff;
      st_in[0].sq      = 20'(ax) * 20'(ax) + 20'(ay) * 20'(ay);
      st_in[0].root    = '0;
      st_in[0].sx      = sx_ff;
      st_in[0].ay      = ay;
      st_in[0].sy_zero = (sy_ff == '0);
      st_in[0].sy_neg  = sy_ff[10];
      st_in[0].below   = '0;
      st_in[0].last    = b_last_ff;

      // one root bit per stage, and one direction edge per stage until every edge is tested
      for (int i = 0; i < NSQ; i++) begin
         logic [7:0]         t;
         logic [15:0]        tt;
         logic signed [52:0] cr;
         t  = st_ff[i].root | (8'h80 >> i);
         tt = 16'(t) * 16'(t) - 16'(t);
         cr = '0;
         st_in[i+1] = st_ff[i];
         if (20'(tt) < st_ff[i].sq) begin
            st_in[i+1].root = t;
         end
         if (i < 5) begin
            cr = 53'(st_ff[i].sx) * 53'(DIR_SIN[i])
               - 53'($signed({1'b0, st_ff[i].ay})) * 53'(DIR_COS[i]);
            st_in[i+1].below[i] = (cr > 0);
         end
      end
   end

   always_comb begin
      st_type f;
      f = st_ff[NSQ];
      if (f.sy_zero) begin
         dir_in = DIR_0;
      end else if (!f.sy_neg) begin
         if (f.below[1]) begin
            dir_in = DIR_0;
         end else if (f.below[2]) begin
            dir_in = DIR_45;
         end else if (f.below[3]) begin
            dir_in = DIR_90;
         end else if (f.below[4]) begin
            dir_in = DIR_135;
         end else begin
            dir_in = DIR_180;
         end
      end else begin
         if (f.below[0] || !f.below[4]) begin
            dir_in = DIR_0;
         end else if (!f.below[3]) begin
            dir_in = DIR_45;
         end else if (!f.below[2]) begin
            dir_in = DIR_90;
         end else if (!f.below[1]) begin
            dir_in = DIR_135;
         end else begin
            dir_in = DIR_180;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i <= NSQ; i++) begin
            st_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         a_valid_ff   <= q_valid;
         b_valid_ff   <= a_valid_ff;
         for (int i = 0; i <= NSQ; i++) begin
            st_ff[i] <= st_in[i];
         end
         out_valid_ff <= st_ff[NSQ].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         a_last_ff <= q_data.last;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         b_last_ff <= a_last_ff;
         mag_ff    <= st_ff[NSQ].root;
         dir_ff    <= dir_in;
         last_ff   <= st_ff[NSQ].last;
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.magnitude     = mag_ff;
   assign rsp_port.direction_bin = dir_ff;
   assign rsp_port.frame_last    = last_ff;

endmodule

/* dv/tb_sobel_gradient_magnitude_direction.sv */
// ---------------------------------------------------------------------------
// Sobel gradient magnitude/direction testbench
// Streams framed pixel words through the block under random back-pressure and
// compares every result word with an in-bench predictor of the window, the
// scaled kernels, the rounded magnitude and the direction bin.
// ---------------------------------------------------------------------------

// Predicts the result words of the filter and checks the ones that arrive.
class sobel_scoreboard;
   typedef struct {
      logic [7:0] magnitude;
      logic [2:0] direction_bin;
      logic       frame_last;
   } grad_word_type;

   // unit vectors at 1, 23, 68, 113, 158 degrees, scaled by 1e12
   longint edge_cos[5] = '{64'sd999847695156, 64'sd920504853452, 64'sd374606593416,
                           -64'sd390731128489, -64'sd927183854567};
   longint edge_sin[5] = '{64'sd17452406437, 64'sd390731128489, 64'sd927183854567,
                           64'sd920504853452, 64'sd374606593416};

   logic [10:0]   cfg_width;
   logic [12:0]   cfg_height;
   logic [7:0]    prev_row [1024];
   logic [7:0]    prev_prev_row [1024];
   logic [7:0]    win [9];
   int            col;
   int            row;
   grad_word_type pending_grads [$];
   int            mismatches;
   int            words_in;
   int            words_out;
   int            last_seen;

   function new();
      cfg_width  = 11'd640;
      cfg_height = 13'd480;
      foreach (prev_row[i]) begin
         prev_row[i] = 8'd0;
         prev_prev_row[i] = 8'd0;
      end
      restart();
      mismatches = 0;
      words_in = 0;
      words_out = 0;
      last_seen = 0;
   endfunction

   function void restart();
      col = 0;
      row = 0;
      foreach (win[i]) win[i] = 8'd0;
   endfunction

   function void configure(logic idx, logic [31:0] value);
      if (idx == sgm_pkg::REG_WIDTH) cfg_width = value[10:0];
      else cfg_height = value[12:0];
      restart();
   endfunction

   function void shift_column(logic [7:0] t, logic [7:0] m, logic [7:0] b);
      win[0] = win[1]; win[1] = win[2]; win[2] = t;
      win[3] = win[4]; win[4] = win[5]; win[5] = m;
      win[6] = win[7]; win[7] = win[8]; win[8] = b;
   endfunction

   function bit below_edge(longint x, longint y, int k);
      return x * edge_sin[k] - y * edge_cos[k] > 0;
   endfunction

   function logic [2:0] bin_of(int sx, int sy);
      longint ny;
      ny = -sy;
      if (sy == 0) return sgm_pkg::DIR_0;
      if (sy > 0) begin
         if (below_edge(sx, sy, 1)) return sgm_pkg::DIR_0;
         if (below_edge(sx, sy, 2)) return sgm_pkg::DIR_45;
         if (below_edge(sx, sy, 3)) return sgm_pkg::DIR_90;
         if (below_edge(sx, sy, 4)) return sgm_pkg::DIR_135;
         return sgm_pkg::DIR_180;
      end
      // negative angle folds to 180 minus the truncated angle of (sx,-sy)
      if (below_edge(sx, ny, 0)) return sgm_pkg::DIR_0;
      if (!below_edge(sx, ny, 4)) return sgm_pkg::DIR_0;
      if (!below_edge(sx, ny, 3)) return sgm_pkg::DIR_45;
      if (!below_edge(sx, ny, 2)) return sgm_pkg::DIR_90;
      if (!below_edge(sx, ny, 1)) return sgm_pkg::DIR_135;
      return sgm_pkg::DIR_180;
   endfunction

   function logic [7:0] root_of(int sx, int sy);
      int s;
      int n;
      s = sx * sx + sy * sy;
      n = 0;
      if (s > 255 * 255 + 255) return 8'd255;
      while ((n + 1) * (n + 1) <= s) n++;
      if (s > n * n + n) n++;
      return n[7:0];
   endfunction

   function void push_grad(bit last);
      int gx;
      int gy;
      grad_word_type g;
      gx = -win[0] + win[2] - 2 * win[3] + 2 * win[5] - win[6] + win[8];
      gy = -win[0] - 2 * win[1] - win[2] + win[6] + 2 * win[7] + win[8];
      gx = gx * 7 / 10;
      gy = gy * 7 / 10;
      g.magnitude = root_of(gx, gy);
      g.direction_bin = bin_of(gx, gy);
      g.frame_last = last;
      pending_grads.push_back(g);
   endfunction

   // one accepted pixel word
   function void note_word(logic [7:0] pix, logic fl);
      int w;
      int h;
      logic [7:0] t, m, b;
      w = (cfg_width == 0) ? 1 : (cfg_width > 1024 ? 1024 : int'(cfg_width));
      h = (cfg_height == 0) ? 1 : (cfg_height > 4096 ? 4096 : int'(cfg_height));
      words_in++;
      if (col >= w || row > h + 1) restart();
      if (fl && row < h) return;   // stray flush mid-frame
      t = (row >= 2) ? prev_prev_row[col] : 8'd0;
      m = (row >= 1) ? prev_row[col] : 8'd0;
      b = (row < h) ? pix : 8'd0;
      if (col == 0) begin
         if (row >= 2) begin
            shift_column(8'd0, 8'd0, 8'd0);
            push_grad(row == h + 1);
         end
         foreach (win[i]) win[i] = 8'd0;
         win[2] = t;
         win[5] = m;
         win[8] = b;
      end else begin
         shift_column(t, m, b);
         if (row >= 1) push_grad(1'b0);
      end
      prev_prev_row[col] = prev_row[col];
      prev_row[col] = b;
      if (row == h + 1) restart();
      else begin
         col++;
         if (col >= w) begin
            col = 0;
            row++;
         end
      end
   endfunction

   function void fail_note(string what, grad_word_type e, grad_word_type a);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH %s: expected mag %0d dir %0d last %0d, got mag %0d dir %0d last %0d",
                  what, e.magnitude, e.direction_bin, e.frame_last,
                  a.magnitude, a.direction_bin, a.frame_last);
   endfunction

   function void check_grad(logic [7:0] mag, logic [2:0] dir, logic last);
      grad_word_type a;
      grad_word_type e;
      a.magnitude = mag;
      a.direction_bin = dir;
      a.frame_last = last;
      words_out++;
      if (last) last_seen++;
      if (pending_grads.size() == 0) begin
         e = '{8'd0, 3'd0, 1'b0};
         fail_note("unexpected word", e, a);
         return;
      end
      e = pending_grads.pop_front();
      if (a.magnitude !== e.magnitude || a.direction_bin !== e.direction_bin ||
          a.frame_last !== e.frame_last)
         fail_note("field", e, a);
   endfunction

   function int pending();
      return pending_grads.size();
   endfunction
endclass

module tb_sobel_gradient_magnitude_direction;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_WIDTH  = 3'h0;
   localparam logic [2:0] ADDR_HEIGHT = 3'h4;
   localparam int DRAIN_CYCLES = 40;   // back-end pipeline is 12 deep

   // pixel content styles
   localparam int STYLE_UNIFORM = 0;
   localparam int STYLE_BINARY  = 1;
   localparam int STYLE_RAMP    = 2;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   sgm_req_if req ();
   sgm_rsp_if rsp ();

   sobel_scoreboard sb;
   bit burst_mode;       // sender offers back to back
   bit hold_off_request; // asks the receiver for one long stall
   int frames_run;

   sobel_gradient_magnitude_direction u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req),
      .rsp_port (rsp),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog: far above the slowest correct run.
   initial begin
      #20ms;
      $display("tb_sobel_gradient_magnitude_direction NOT OK");
      $finish;
   end

   // Result side: values are stable by the falling edge, so sample there.
   always @(negedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_grad(rsp.magnitude, rsp.direction_bin, rsp.frame_last);
   end

   // Receiver back-pressure: mostly short gaps, a few long, open stretches,
   // and on request one long hold-off so the line pipe backs up into req.
   initial begin
      int n;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            n = $urandom_range(1, 30);
            rsp.ready <= 1'b1;
            repeat (n) @(posedge clock);
            n = $urandom_range(0, 15);
            if (n < 9) n = n / 4;
            else if (n < 14) n = $urandom_range(1, 4);
            else n = $urandom_range(20, 60);
            if (n > 0) begin
               rsp.ready <= 1'b0;
               repeat (n - 1) @(posedge clock);
            end
         end
      end
   end

   // Offers one pixel word; returns on the edge that took it.
   task automatic send_word(logic [7:0] pix, logic fl);
      int gap;
      gap = 0;
      if (!burst_mode) begin
         gap = $urandom_range(0, 63);
         if (gap < 48) gap = 0;
         else if (gap < 62) gap = $urandom_range(1, 3);
         else gap = $urandom_range(15, 50);
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pixel <= pix;
      req.flush <= fl;
      forever begin
         @(negedge clock);
         if (req.ready) break;
      end
      @(posedge clock);
      sb.note_word(pix, fl);
   endtask

   // Stops offering and waits until every predicted word is back.
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.configure(addr[2], value);
   endtask

   task automatic set_size(int w, int h);
      drain();
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
   endtask

   function automatic logic [7:0] pick_pixel(int style, int x, int y);
      case (style)
         STYLE_UNIFORM: return 8'($urandom_range(0, 255));
         STYLE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         default: return 8'(x * 9 + y * 5 + $urandom_range(0, 7));
      endcase
   endfunction

   // One frame: pixels, then width+1 flush words; a few stray words mixed in.
   task automatic run_frame(int w, int h, int style);
      int ew;
      int eh;
      ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
      eh = (h == 0) ? 1 : (h > 4096 ? 4096 : h);
      for (int y = 0; y < eh; y++) begin
         for (int x = 0; x < ew; x++) begin
            if ($urandom_range(0, 99) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
            send_word(pick_pixel(style, x, y), 1'b0);
         end
      end
      // a pixel word in the flush phase counts as flush
      for (int i = 0; i <= ew; i++)
         send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 9) != 0));
      frames_run++;
   endtask

   initial begin
      int w;
      int h;
      logic [7:0] img [9];
      sb = new();
      burst_mode = 1'b0;
      hold_off_request = 1'b0;
      frames_run = 0;
      reset   = 1'b1;
      req.valid = 1'b0;
      req.pixel = 8'd0;
      req.flush = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = 3'd0;
      pwdata  = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed 3x3: bright left side (negative x gradient folds to bin 0), then
      // a flat frame (zero gradient).
      set_size(3, 3);
      img = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
              8'd255, 8'd255, 8'd0};
      send_word(8'd77, 1'b1);            // stray flush before the frame
      foreach (img[i]) send_word(img[i], 1'b0);
      repeat (4) send_word(8'd0, 1'b1);
      repeat (9) send_word(8'd128, 1'b0);  // flat frame
      repeat (4) send_word(8'd255, 1'b1);

      // Register corners: zero sizes, single pixel, single column and row.
      set_size(1, 1);     run_frame(1, 1, STYLE_UNIFORM);
      set_size(0, 0);     run_frame(0, 0, STYLE_UNIFORM);
      set_size(1, 40);    run_frame(1, 40, STYLE_RAMP);
      set_size(40, 1);    run_frame(40, 1, STYLE_BINARY);

      // Random frames, mostly small; one long receiver hold-off on the way.
      w = 5;
      h = 4;
      set_size(w, h);
      while (sb.words_in < 1800) begin
         if ($urandom_range(0, 2) == 0) begin
            w = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 16) : $urandom_range(17, 64);
            h = $urandom_range(1, 8);
            set_size(w, h);
         end
         burst_mode = ($urandom_range(0, 3) == 0);
         if (frames_run == 12) begin
            // a frame long enough to back the block up during the hold-off
            w = 64;
            h = 8;
            set_size(w, h);
            burst_mode = 1'b1;
            hold_off_request = 1'b1;
         end
         run_frame(w, h, $urandom_range(0, 2));
      end

      drain();
      $display("Ran %0d frames: %0d pixel words in, %0d result words out, %0d frame ends.",
               frames_run, sb.words_in, sb.words_out, sb.last_seen);
      $display("Mismatches: %0d, words still awaited: %0d", sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_sobel_gradient_magnitude_direction OK");
      else
         $display("tb_sobel_gradient_magnitude_direction NOT OK");
      $finish;
   end
endmodule
